FILE: rtl/omni_wheel_drive_mixer_assert.svh
// Assertion macros used by the drive mixer back end.
`ifndef OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH
`define OMNI_WHEEL_DRIVE_MIXER_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define OWDM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define OWDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/owdm_pkg.sv
`timescale 1ns / 1ps
package owdm_pkg;
	localparam int TrigFracBitsDefault = 15;
	localparam int DirW = 9;
	localparam int SpdW = 7;
	localparam int HdgW = 9;
	localparam int CfgDataW = 9;
	localparam int CfgIdxW = 3;
	localparam int WheelAngle = 50;
	localparam int SmallError = 13;
	localparam int SlowTurn = 15;
	localparam int OffDirection = 360;

	localparam logic [CfgIdxW-1:0] REG_TURN_THRESHOLD = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TURN_SPEED     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_STOP_CODE      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MOTOR_REVERSE  = 3'd4;

	// Heading action chosen by the front end.
	localparam logic [1:0] ACT_MIX  = 2'd0;
	localparam logic [1:0] ACT_FLAT = 2'd1;
	localparam logic [1:0] ACT_CORR = 2'd2;
	localparam logic [1:0] ACT_OFF  = 2'd3;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		logic [8:0]        quad_a;   // quadrant angle for cosine
		logic              neg_a;
		logic [8:0]        quad_b;   // quadrant angle for sine
		logic              neg_b;
		logic [SpdW-1:0]   speed;
		logic [1:0]        action;
		logic signed [9:0] flat;     // common speed for turn actions
		logic signed [11:0] corr;    // 2*error to subtract
	} cmd_t;

	// Q31 sine of a whole degree 0..90 by the truncated Taylor series.
	function automatic logic [63:0] sine_q31(input int k);
		logic [63:0] x, x2, term, sum;
		x = (64'(k) * 64'd6746518737) / 64'd180;
		x2 = (x * x) >> 31;
		sum = x;
		term = x;
		for (int n = 1; n <= 13; n++) begin
			term = ((term * x2) >> 31) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				sum = (sum >= term) ? sum - term : 64'd0;
			else
				sum = sum + term;
		end
		return sum;
	endfunction
endpackage

FILE: rtl/owdm_front.sv
`timescale 1ns / 1ps
module owdm_front import owdm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [DirW-1:0] travel_direction,
	input  logic [SpdW-1:0] travel_speed,
	input  logic [HdgW-1:0] target_heading,
	input  logic [HdgW-1:0] compass_heading,
	input  logic [7:0]      turn_threshold,
	input  logic [6:0]      turn_speed,
	input  logic [8:0]      stop_code,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output cmd_t            cmd
);
	logic [8:0]         dmod, dc;
	logic signed [11:0] tg, cu, err;
	logic [11:0]        aerr;
	cmd_t               nxt;
	logic               negf;

	// Quadrant reduction of an angle in 0..449 for the sine symmetry.
	function automatic logic [9:0] quad(input logic [9:0] d0);
		logic [9:0] d;
		d = (d0 >= 10'd360) ? d0 - 10'd360 : d0;
		if (d <= 10'd90) return {1'b0, d[8:0]};
		else if (d <= 10'd180) return {1'b0, 9'(10'd180 - d)};
		else if (d <= 10'd270) return {1'b1, 9'(d - 10'd180)};
		else return {1'b1, 9'(10'd360 - d)};
	endfunction

	always_comb begin
		logic [9:0] qa, qb;
		dmod = (travel_direction >= 9'd360) ? travel_direction - 9'd360 : travel_direction;
		dc = dmod;
		qa = quad(10'(dc) + 10'd90);
		qb = quad(10'(dc));
		tg = 12'(target_heading);
		cu = 12'(compass_heading);
		if (tg < 12'sd180)
			err = (cu > tg + 12'sd180) ? cu - tg - 12'sd360 : cu - tg;
		else
			err = (cu > tg - 12'sd180) ? cu - tg : 12'sd360 - tg + cu;
		aerr = err[11] ? 12'(-err) : 12'(err);
		negf = err[11];
		nxt.quad_a = qa[8:0];
		nxt.neg_a = qa[9];
		nxt.quad_b = qb[8:0];
		nxt.neg_b = qb[9];
		nxt.speed = travel_speed;
		nxt.corr = err <<< 1;
		nxt.flat = '0;
		if (travel_direction == 9'(OffDirection)) begin
			nxt.action = ACT_OFF;
		end else if (aerr > 12'(turn_threshold)) begin
			nxt.action = ACT_FLAT;
			nxt.flat = negf ? 10'(turn_speed) : -10'(turn_speed);
		end else if (aerr > 12'(SmallError)) begin
			if (travel_direction == stop_code) begin
				nxt.action = ACT_FLAT;
				nxt.flat = negf ? 10'(SlowTurn) : -10'(SlowTurn);
			end else begin
				nxt.action = ACT_CORR;
			end
		end else begin
			nxt.action = ACT_MIX;
		end
	end

	// Two-entry queue toward the back end.
	cmd_t       fifo_q [2];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= nxt;
	end
endmodule

FILE: rtl/owdm_back.sv
`timescale 1ns / 1ps
module owdm_back import owdm_pkg::*; #(
	parameter int TRIG_FRACTION_BITS = TrigFracBitsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	input  logic [6:0] speed_limit,
	input  logic [3:0] motor_reverse,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       dir_a,
	output logic [7:0] pwm_a,
	output logic       dir_b,
	output logic [7:0] pwm_b,
	output logic       dir_c,
	output logic [7:0] pwm_c,
	output logic       dir_d,
	output logic [7:0] pwm_d
);
	localparam int TW = TRIG_FRACTION_BITS + 2;
	localparam int PW = 2 * TW + 1;
	localparam int QW = SpdW + PW;
	localparam int CntW = $clog2(SpdW + 1);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;
	// For x below 128, x*255/100 equals (x*PwmScale) >> 19 exactly.
	localparam logic [27:0] PwmScale = 28'd1336965;

	typedef logic [TW-2:0] sin_rom_t [91];

	function automatic sin_rom_t build_rom();
		sin_rom_t r;
		for (int k = 0; k <= 90; k++)
			r[k] = (TW-1)'(sine_q31(k) >> (31 - TRIG_FRACTION_BITS));
		return r;
	endfunction

	localparam sin_rom_t SinRom = build_rom();
	localparam logic signed [TW-1:0] SinW = TW'(SinRom[WheelAngle]);
	localparam logic signed [TW-1:0] CosW = TW'(SinRom[90 - WheelAngle]);

	logic [2:0]            st_q;
	cmd_t                  c_q;
	logic signed [PW-1:0]  u1_q, u2_q;
	logic [PW-1:0]         den_q, rem_q;
	logic [SpdW-1:0]       lo_q, quo_q;
	logic [CntW-1:0]       bit_q;
	logic                  big1_q, sbig_q, ssmall_q, zero_q;
	logic                  out_valid_q;
	logic [3:0]            dir_q;
	logic [7:0]            pwm_q [4];
	logic signed [TW-1:0]  cv, sv;
	logic [PW-1:0]         m1, m2;
	logic                  big1;
	logic [QW-1:0]         num;
	logic [PW+1:0]         trial;
	logic                  out_load;

	assign cmd_ready = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_load = (st_q == ST_OUT) && (!out_valid_q || out_ready);
	assign cv = c_q.neg_a ? -TW'(SinRom[c_q.quad_a[6:0]]) : TW'(SinRom[c_q.quad_a[6:0]]);
	assign sv = c_q.neg_b ? -TW'(SinRom[c_q.quad_b[6:0]]) : TW'(SinRom[c_q.quad_b[6:0]]);
	assign m1 = u1_q[PW-1] ? PW'(-u1_q) : PW'(u1_q);
	assign m2 = u2_q[PW-1] ? PW'(-u2_q) : PW'(u2_q);
	assign big1 = (m1 > m2);
	assign num = QW'(c_q.speed) * QW'(big1 ? m2 : m1);
	assign trial = {1'b0, rem_q, lo_q[SpdW-1]} - {2'b00, den_q};

	function automatic logic [8:0] drive(input logic signed [10:0] s0, input logic rev,
			input logic [6:0] lim);
		logic signed [11:0] s, l;
		logic [6:0] x;
		logic [27:0] p;
		logic [8:0] q;
		s = rev ? -12'(s0) : 12'(s0);
		l = 12'(lim);
		if (s > l) s = l;
		else if (s < -l) s = -l;
		x = s[11] ? 7'(-s) : 7'(s);
		p = 28'(x) * PwmScale;
		q = p[27:19];
		if (!s[11]) return {1'b0, (q > 9'd255) ? 8'd255 : q[7:0]};
		return {1'b1, (q > 9'd255) ? 8'd0 : 8'(9'd255 - q)};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (st_q)
				ST_IDLE: if (cmd_valid) st_q <= ST_MUL;
				ST_MUL: st_q <= ST_SETUP;
				ST_SETUP: st_q <= ST_DIV;
				ST_DIV: if (bit_q == CntW'(1)) st_q <= ST_OUT;
				ST_OUT: if (out_load) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// The quotient never exceeds the speed, so only SpdW restoring steps are needed;
	// the upper bits of the product already sit below the divisor.
	always_ff @(posedge clk) begin
		logic signed [10:0] big, lesser, q;
		logic signed [10:0] m [4];
		logic [8:0] r;
		unique case (st_q)
			ST_IDLE: if (cmd_valid) c_q <= cmd;
			ST_MUL: begin
				u1_q <= PW'(cv * SinW) - PW'(sv * CosW);
				u2_q <= PW'(cv * SinW) + PW'(sv * CosW);
			end
			ST_SETUP: begin
				big1_q <= big1;
				sbig_q <= big1 ? u1_q[PW-1] : u2_q[PW-1];
				ssmall_q <= big1 ? u2_q[PW-1] : u1_q[PW-1];
				zero_q <= !big1 && (u2_q == '0);
				den_q <= big1 ? m1 : m2;
				rem_q <= num[QW-1:SpdW];
				lo_q <= num[SpdW-1:0];
				quo_q <= '0;
				bit_q <= CntW'(SpdW);
			end
			ST_DIV: begin
				lo_q <= lo_q << 1;
				if (!trial[PW+1]) begin
					rem_q <= trial[PW-1:0];
					quo_q <= {quo_q[SpdW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[PW-2:0], lo_q[SpdW-1]};
					quo_q <= {quo_q[SpdW-2:0], 1'b0};
				end
				bit_q <= bit_q - CntW'(1);
			end
			ST_OUT: if (out_load) begin
				big = sbig_q ? -11'(c_q.speed) : 11'(c_q.speed);
				q = 11'(quo_q);
				lesser = ssmall_q ? -q : q;
				if (zero_q) begin
					m[0] = '0; m[1] = '0;
				end else if (big1_q) begin
					m[0] = big; m[1] = lesser;
				end else begin
					m[0] = lesser; m[1] = big;
				end
				m[2] = -m[0];
				m[3] = -m[1];
				for (int i = 0; i < 4; i++) begin
					unique case (c_q.action)
						ACT_OFF: m[i] = '0;
						ACT_FLAT: m[i] = 11'(c_q.flat);
						ACT_CORR: m[i] = m[i] - 11'(c_q.corr);
						ACT_MIX: ;
					endcase
					r = drive(m[i], motor_reverse[i], speed_limit);
					dir_q[i] <= r[8];
					pwm_q[i] <= r[7:0];
				end
			end
			default: ;
		endcase
	end

	assign dir_a = dir_q[0];
	assign pwm_a = pwm_q[0];
	assign dir_b = dir_q[1];
	assign pwm_b = pwm_q[1];
	assign dir_c = dir_q[2];
	assign pwm_c = pwm_q[2];
	assign dir_d = dir_q[3];
	assign pwm_d = pwm_q[3];

`include "omni_wheel_drive_mixer_assert.svh"
	`OWDM_ASSERT_IMPL(a_ready_idle, clk, arst_n, cmd_ready, st_q == ST_IDLE, "ready outside idle")
	`OWDM_ASSERT_NEXT(a_take, clk, arst_n, cmd_valid && cmd_ready, st_q == ST_MUL, "take missed")
	`OWDM_ASSERT_NEXT(a_mul, clk, arst_n, st_q == ST_MUL, st_q == ST_SETUP, "setup skipped")
	`OWDM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

FILE: rtl/omni_wheel_drive_mixer.sv
`timescale 1ns / 1ps
// Four-wheel omni drive mixer: a front end classifies each command (heading
// error, turn or correction choice, quadrant of the direction) and queues it;
// the back end mixes the wheel speeds with a one-bit-per-cycle divider and
// maps them to direction and PWM. For each command the back end takes it,
// forms the products, sets up the divider, runs seven divide steps (one per
// speed bit, since the quotient never exceeds the speed) and loads the output
// register; it takes no new command until that result is loaded. The front
// end accepts commands back to back into its two-entry queue; while a result
// waits on out_ready the back end holds and, once the queue is full, in_ready
// drops.
module omni_wheel_drive_mixer import owdm_pkg::*; #(
	parameter int TRIG_FRACTION_BITS = TrigFracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DirW-1:0]     travel_direction,
	input  logic [SpdW-1:0]     travel_speed,
	input  logic [HdgW-1:0]     target_heading,
	input  logic [HdgW-1:0]     compass_heading,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                dir_a,
	output logic [7:0]          pwm_a,
	output logic                dir_b,
	output logic [7:0]          pwm_b,
	output logic                dir_c,
	output logic [7:0]          pwm_c,
	output logic                dir_d,
	output logic [7:0]          pwm_d
);
	logic [7:0] thr_q;
	logic [6:0] tspd_q, lim_q;
	logic [8:0] stop_q;
	logic [3:0] rev_q;
	logic       cmd_valid, cmd_ready;
	cmd_t       cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 8'd40;
			tspd_q <= 7'd30;
			lim_q <= 7'd100;
			stop_q <= 9'd360;
			rev_q <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TURN_THRESHOLD: thr_q <= cfg_data[7:0];
				REG_TURN_SPEED: tspd_q <= cfg_data[6:0];
				REG_SPEED_LIMIT: lim_q <= cfg_data[6:0];
				REG_STOP_CODE: stop_q <= cfg_data;
				REG_MOTOR_REVERSE: rev_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	owdm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .travel_direction, .travel_speed,
		.target_heading, .compass_heading, .turn_threshold(thr_q), .turn_speed(tspd_q),
		.stop_code(stop_q), .cmd_valid, .cmd_ready, .cmd
	);

	owdm_back #(.TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .speed_limit(lim_q),
		.motor_reverse(rev_q), .out_valid, .out_ready, .dir_a, .pwm_a, .dir_b, .pwm_b,
		.dir_c, .pwm_c, .dir_d, .pwm_d
	);
endmodule
